// File: hdl/ttrbp_pkg.sv
// Shared types and constants for the two-tier refcounted block pool.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ttrbp_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int ADDR_W     = $clog2(MAX_BLOCKS);
   localparam int ID_W       = ADDR_W + 1;
   localparam int CNT_W      = 16;
   localparam int FRAC_W     = 17;
   localparam int CSR_IDX_W  = 2;

   localparam logic [ID_W-1:0]   ID_NONE   = ID_W'(MAX_BLOCKS);
   localparam logic [FRAC_W-1:0] FRAC_FULL = 17'd65536;
   localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

   // opcodes
   localparam logic [2:0] OP_ALLOC_FAST = 3'd0;
   localparam logic [2:0] OP_ALLOC_SLOW = 3'd1;
   localparam logic [2:0] OP_BUMP       = 3'd2;
   localparam logic [2:0] OP_FREE       = 3'd3;
   localparam logic [2:0] OP_QUERY      = 3'd4;
   localparam logic [2:0] OP_TEST_FAST  = 3'd5;
   localparam logic [2:0] OP_TEST_SLOW  = 3'd6;
   localparam logic [2:0] OP_REBUILD    = 3'd7;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_DOUBLE   = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;
   localparam logic [2:0] ST_BUMPFREE = 3'd5;
   localparam logic [2:0] ST_SAT      = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE    = 2'd2;

   typedef struct packed {
      logic [2:0]      opcode;
      logic [ID_W-1:0] target_id;
      logic [ID_W-1:0] request_count;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  granted_id;
      logic [2:0]       status;
      logic [CNT_W-1:0] ref_count;
      logic             in_fast_tier;
      logic             enough_free;
      logic             released;
      logic [ID_W-1:0]  fast_free_count;
      logic [ID_W-1:0]  slow_free_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic              accept;
      logic              exec;
      logic              latch_cfg;
      logic              mul_fast;
      logic              mul_slow;
      logic              sweep;
      logic [ADDR_W-1:0] sweep_idx;
      logic              load_rebuild;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_rebuild;
      logic out_block;
   } stat_type;

endpackage

// File: hdl/ttrbp_ctrl.sv
// Controller of the block pool: sequences accept, execute, rebuild and sweeps.
// Depends on ttrbp_pkg.
`timescale 1ns / 1ps

module ttrbp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ttrbp_pkg::stat_type stat,
   output ttrbp_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_LATCH, S_MUL_F, S_MUL_S, S_SWEEP, S_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [ttrbp_pkg::ADDR_W-1:0]   idx_ff, idx_in;
   logic                           accept;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   // decode commands and next state
   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      cmd              = '0;
      cmd.accept       = accept;
      cmd.sweep_idx    = idx_ff;
      case (state_ff)
         S_CLEAR, S_SWEEP: begin
            cmd.sweep = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (&idx_ff) begin
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = stat.is_rebuild ? S_LATCH : S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.out_block) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LATCH: begin
            cmd.latch_cfg = 1'b1;
            state_in      = S_MUL_F;
         end
         S_MUL_F: begin
            cmd.mul_fast = 1'b1;
            state_in     = S_MUL_S;
         end
         S_MUL_S: begin
            cmd.mul_slow = 1'b1;
            idx_in       = '0;
            state_in     = S_SWEEP;
         end
         S_DONE: begin
            if (!stat.out_block) begin
               cmd.load_rebuild = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and sweep index
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// File: hdl/ttrbp_datapath.sv
// Datapath of the block pool: count and stack memories, tops, limits,
// reserves, configuration registers and the result register. Uses ttrbp_pkg.
`timescale 1ns / 1ps

module ttrbp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ttrbp_pkg::req_type                  req_data,
   output ttrbp_pkg::rsp_type                  rsp_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                csr_write_en,
   input  logic [ttrbp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttrbp_pkg::FRAC_W-1:0]        csr_data,
   input  ttrbp_pkg::cmd_type                  cmd,
   output ttrbp_pkg::stat_type                 stat
);

   localparam int IW = ttrbp_pkg::ID_W;
   localparam int AW = ttrbp_pkg::ADDR_W;
   localparam int CW = ttrbp_pkg::CNT_W;
   localparam int FW = ttrbp_pkg::FRAC_W;
   localparam int PW = IW + FW;

   logic [CW-1:0] counts [ttrbp_pkg::MAX_BLOCKS];
   logic [AW-1:0] fast_stack [ttrbp_pkg::MAX_BLOCKS];
   logic [AW-1:0] slow_stack [ttrbp_pkg::MAX_BLOCKS];

   logic [IW-1:0] fcfg_ff, scfg_ff;
   logic [FW-1:0] frac_cfg_ff, frac_ff;
   logic [IW-1:0] fl_ff, sl_ff, fres_ff, sres_ff, ftop_ff, stop_ff;
   logic [IW-1:0] ftop_in, stop_in;
   ttrbp_pkg::req_type rq_ff;
   logic [CW-1:0] cnt_rd_ff;
   logic [AW-1:0] fstk_rd_ff, sstk_rd_ff;
   ttrbp_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff;

   logic [IW-1:0] f_clamp, s_clamp, s_room;
   logic [FW-1:0] fr_clamp;
   logic [IW-1:0] mul_n;
   logic [PW-1:0] prod;
   logic [IW-1:0] res_q;
   logic [IW-1:0] ftop_m1, stop_m1;

   logic          cnt_we;
   logic [AW-1:0] cnt_wa;
   logic [CW-1:0] cnt_wd;
   logic          fpush, spush;

   assign stat.is_rebuild = (req_data.opcode == ttrbp_pkg::OP_REBUILD);
   assign stat.out_block  = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   // clamp configuration for rebuild
   always_comb begin
      f_clamp  = (fcfg_ff > ttrbp_pkg::ID_NONE) ? ttrbp_pkg::ID_NONE : fcfg_ff;
      s_room   = ttrbp_pkg::ID_NONE - f_clamp;
      s_clamp  = (scfg_ff > s_room) ? s_room : scfg_ff;
      fr_clamp = (frac_cfg_ff > ttrbp_pkg::FRAC_FULL) ? ttrbp_pkg::FRAC_FULL : frac_cfg_ff;
   end

   // reserve = ceil(n * frac / 65536), one shared multiplier
   assign mul_n = cmd.mul_slow ? sl_ff : fl_ff;
   assign prod  = {{FW{1'b0}}, mul_n} * {{IW{1'b0}}, frac_ff} + PW'(16'hFFFF);
   assign res_q = prod[IW+15:16];

   assign ftop_m1 = ftop_ff - 1'b1;
   assign stop_m1 = stop_ff - 1'b1;

   // execute one operation on the read data
   always_comb begin
      logic [IW:0]   total;
      logic [IW-1:0] avail, resv;
      logic [CW-1:0] cnt_new;
      logic          is_fast;
      total   = {1'b0, fl_ff} + {1'b0, sl_ff};
      avail   = '0;
      resv    = '0;
      cnt_new = cnt_rd_ff;
      is_fast = (rq_ff.target_id < fl_ff);
      ftop_in = ftop_ff;
      stop_in = stop_ff;
      cnt_we  = 1'b0;
      cnt_wa  = rq_ff.target_id[AW-1:0];
      cnt_wd  = '0;
      fpush   = 1'b0;
      spush   = 1'b0;
      rsp_in  = '0;
      rsp_in.granted_id = ttrbp_pkg::ID_NONE;
      rsp_in.status     = ttrbp_pkg::ST_OK;
      case (rq_ff.opcode)
         ttrbp_pkg::OP_ALLOC_FAST, ttrbp_pkg::OP_ALLOC_SLOW: begin
            if (rq_ff.opcode == ttrbp_pkg::OP_ALLOC_FAST) begin
               avail = ftop_ff;
               cnt_wa = fstk_rd_ff;
            end else begin
               avail = stop_ff;
               cnt_wa = sstk_rd_ff;
            end
            if (avail == '0) begin
               rsp_in.status = ttrbp_pkg::ST_EMPTY;
            end else begin
               if (rq_ff.opcode == ttrbp_pkg::OP_ALLOC_FAST) ftop_in = ftop_m1;
               else stop_in = stop_m1;
               cnt_we = 1'b1;
               cnt_wd = CW'(1);
               rsp_in.granted_id   = {1'b0, cnt_wa};
               rsp_in.ref_count    = CW'(1);
               rsp_in.in_fast_tier = ({1'b0, cnt_wa} < fl_ff);
            end
         end
         ttrbp_pkg::OP_BUMP, ttrbp_pkg::OP_FREE, ttrbp_pkg::OP_QUERY: begin
            if (rq_ff.target_id == ttrbp_pkg::ID_NONE) begin
               rsp_in.status = ttrbp_pkg::ST_INVALID;
            end else if (rq_ff.target_id > ttrbp_pkg::ID_NONE ||
                         {1'b0, rq_ff.target_id} >= total) begin
               rsp_in.status = ttrbp_pkg::ST_RANGE;
            end else begin
               rsp_in.in_fast_tier = is_fast;
               if (rq_ff.opcode == ttrbp_pkg::OP_BUMP) begin
                  if (cnt_rd_ff == '0) begin
                     rsp_in.status = ttrbp_pkg::ST_BUMPFREE;
                  end else if (cnt_rd_ff == ttrbp_pkg::CNT_MAX) begin
                     rsp_in.status = ttrbp_pkg::ST_SAT;
                  end else begin
                     cnt_new = cnt_rd_ff + 1'b1;
                     cnt_we  = 1'b1;
                  end
               end else if (rq_ff.opcode == ttrbp_pkg::OP_FREE) begin
                  if (cnt_rd_ff == '0) begin
                     rsp_in.status = ttrbp_pkg::ST_DOUBLE;
                  end else begin
                     cnt_new = cnt_rd_ff - 1'b1;
                     cnt_we  = 1'b1;
                     if (cnt_new == '0) begin
                        rsp_in.released = 1'b1;
                        if (is_fast) begin
                           if (ftop_ff < ttrbp_pkg::ID_NONE) begin
                              fpush   = 1'b1;
                              ftop_in = ftop_ff + 1'b1;
                           end
                        end else if (stop_ff < ttrbp_pkg::ID_NONE) begin
                           spush   = 1'b1;
                           stop_in = stop_ff + 1'b1;
                        end
                     end
                  end
               end
               cnt_wd           = cnt_new;
               rsp_in.ref_count = cnt_new;
            end
         end
         ttrbp_pkg::OP_TEST_FAST, ttrbp_pkg::OP_TEST_SLOW: begin
            if (rq_ff.opcode == ttrbp_pkg::OP_TEST_FAST) begin
               avail = ftop_ff;
               resv  = fres_ff;
            end else begin
               avail = stop_ff;
               resv  = sres_ff;
            end
            rsp_in.enough_free = (avail > resv) && (rq_ff.request_count <= avail - resv);
         end
         default: ;
      endcase
      rsp_in.fast_free_count = ftop_in;
      rsp_in.slow_free_count = stop_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fcfg_ff     <= '0;
         scfg_ff     <= '0;
         frac_cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            ttrbp_pkg::CSR_FAST_COUNT: fcfg_ff     <= csr_data[IW-1:0];
            ttrbp_pkg::CSR_SLOW_COUNT: scfg_ff     <= csr_data[IW-1:0];
            ttrbp_pkg::CSR_RESERVE:    frac_cfg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // tier state: limits, reserves, tops
   always_ff @(posedge clock) begin
      if (reset) begin
         fl_ff   <= '0;
         sl_ff   <= '0;
         fres_ff <= '0;
         sres_ff <= '0;
         ftop_ff <= '0;
         stop_ff <= '0;
         frac_ff <= '0;
      end else begin
         if (cmd.latch_cfg) begin
            fl_ff   <= f_clamp;
            sl_ff   <= s_clamp;
            frac_ff <= fr_clamp;
            ftop_ff <= f_clamp;
            stop_ff <= s_clamp;
         end
         if (cmd.mul_fast) fres_ff <= res_q;
         if (cmd.mul_slow) sres_ff <= res_q;
         if (cmd.exec) begin
            ftop_ff <= ftop_in;
            stop_ff <= stop_in;
         end
      end
   end

   // capture request and read memories on accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rq_ff      <= req_data;
         cnt_rd_ff  <= counts[req_data.target_id[AW-1:0]];
         fstk_rd_ff <= fast_stack[ftop_m1[AW-1:0]];
         sstk_rd_ff <= slow_stack[stop_m1[AW-1:0]];
      end
   end

   // count memory: sweep clears, execute writes
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         counts[cmd.sweep_idx] <= '0;
      end else if (cmd.exec && cnt_we) begin
         counts[cnt_wa] <= cnt_wd;
      end
   end

   // stack memories: sweep restacks in descending order, free pushes
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         if ({1'b0, cmd.sweep_idx} < fl_ff) begin
            fast_stack[cmd.sweep_idx] <= AW'(fl_ff - 1'b1 - {1'b0, cmd.sweep_idx});
         end
      end else if (cmd.exec && fpush) begin
         fast_stack[ftop_ff[AW-1:0]] <= rq_ff.target_id[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         if ({1'b0, cmd.sweep_idx} < sl_ff) begin
            slow_stack[cmd.sweep_idx] <=
               AW'(fl_ff + sl_ff - 1'b1 - {1'b0, cmd.sweep_idx});
         end
      end else if (cmd.exec && spush) begin
         slow_stack[stop_ff[AW-1:0]] <= rq_ff.target_id[AW-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end else if (cmd.load_rebuild) begin
         rsp_ff                 <= '0;
         rsp_ff.granted_id      <= ttrbp_pkg::ID_NONE;
         rsp_ff.status          <= ttrbp_pkg::ST_OK;
         rsp_ff.fast_free_count <= ftop_ff;
         rsp_ff.slow_free_count <= stop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec || cmd.load_rebuild) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

// File: hdl/two_tier_refcounted_block_pool.sv
// Two-tier refcounted block pool, top level: a controller and a datapath.
// Depends on ttrbp_pkg, ttrbp_ctrl and ttrbp_datapath.
// Usage: an ordinary operation registers its request beat and the memory
// reads on accept, then executes, writes the memories and loads the result
// register; a stalled result holds the execute state, and no new request
// beat is taken until the operation has executed.
// Rebuild runs from accept to result through configuration latch, the fast
// and slow reserves in turn on the shared reserve multiplier, a sweep that
// clears every count and restacks both tiers one entry per cycle, then the
// result load. After reset the same sweep clears the count memory before
// the first request beat is taken; configuration writes are taken at
// any time and act at the next rebuild.
`timescale 1ns / 1ps

module two_tier_refcounted_block_pool (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ttrbp_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ttrbp_pkg::rsp_type               rsp_data,
   input  logic                             csr_write_en,
   input  logic [ttrbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ttrbp_pkg::FRAC_W-1:0]     csr_data
);

   ttrbp_pkg::cmd_type  cmd;
   ttrbp_pkg::stat_type stat;

   ttrbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttrbp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule

// File: hdl/ttrbp_checker.sv
// Port-level checks for the block pool, bound to the top level.
// Depends on ttrbp_pkg and two_tier_refcounted_block_pool.
`timescale 1ns / 1ps

module ttrbp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ttrbp_pkg::rsp_type rsp_data
);

   // a waiting result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // a grant is a fresh block with one reference
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted_id != ttrbp_pkg::ID_NONE |->
         rsp_data.ref_count == 16'd1 && rsp_data.status == ttrbp_pkg::ST_OK)
      else $error("grant without single reference");

   // a release leaves zero references and succeeds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.released |->
         rsp_data.ref_count == '0 && rsp_data.status == ttrbp_pkg::ST_OK)
      else $error("release with live references");

   // free depths never pass the pool size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.fast_free_count <= ttrbp_pkg::ID_NONE &&
                    rsp_data.slow_free_count <= ttrbp_pkg::ID_NONE)
      else $error("free depth beyond pool size");

endmodule

bind two_tier_refcounted_block_pool ttrbp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
